>>> hdl/texture_mip_chain_size_core_macros.svh
// Assertion macros used by the mip chain size core RTL.
`ifndef TEXTURE_MIP_CHAIN_SIZE_CORE_MACROS_SVH
`define TEXTURE_MIP_CHAIN_SIZE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMCS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TMCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tmcs_pkg.sv
// Types, constants and the format table for the mip chain size core.
`default_nettype none

package tmcs_pkg;

  localparam int unsigned EXTENT_BITS_DEF = 16;
  localparam int unsigned CODE_W          = 5;
  localparam int unsigned REQ_W           = 8;
  localparam int unsigned TOTAL_W         = 36;
  localparam int unsigned LEVELS_OUT_W    = 5;
  localparam int unsigned FMT_ROWS        = 26;

  // x / 3 == (x * 0xAAAAAAAB) >> 33 for any 32-bit x
  localparam logic [63:0] DIV3_RECIP = 64'h0000_0000_AAAA_AAAB;
  localparam int unsigned DIV3_SHIFT = 33;

  typedef enum logic [1:0] {
    BLK_1,
    BLK_4,
    BLK_6,
    BLK_8
  } blk_e;

  // zero: no bytes per block; bsh: log2 of bytes per block
  typedef struct packed {
    logic       zero;
    logic [2:0] bsh;
    blk_e       blk;
  } fmt_row_t;

  // Per-slot control travelling down the cell chain
  typedef struct packed {
    logic     vld;
    logic     bvld;
    logic     pvld;
    logic     unknown;
    fmt_row_t fmt;
  } ctl_t;

  localparam fmt_row_t FMT_NONE = '{zero: 1'b1, bsh: 3'd0, blk: BLK_1};

  localparam fmt_row_t FMT_TABLE [FMT_ROWS] = '{
    '{1'b1, 3'd0, BLK_1},
    '{1'b0, 3'd0, BLK_1}, '{1'b0, 3'd1, BLK_1}, '{1'b0, 3'd2, BLK_1},
    '{1'b0, 3'd2, BLK_1}, '{1'b0, 3'd1, BLK_1},
    '{1'b0, 3'd2, BLK_1}, '{1'b0, 3'd3, BLK_1}, '{1'b0, 3'd2, BLK_1},
    '{1'b0, 3'd2, BLK_1}, '{1'b0, 3'd2, BLK_1},
    '{1'b0, 3'd3, BLK_4}, '{1'b0, 3'd3, BLK_4}, '{1'b0, 3'd4, BLK_4},
    '{1'b0, 3'd4, BLK_4}, '{1'b0, 3'd3, BLK_4},
    '{1'b0, 3'd4, BLK_4}, '{1'b0, 3'd4, BLK_4}, '{1'b0, 3'd4, BLK_4},
    '{1'b0, 3'd4, BLK_4},
    '{1'b0, 3'd4, BLK_4}, '{1'b0, 3'd4, BLK_4}, '{1'b0, 3'd4, BLK_6},
    '{1'b0, 3'd4, BLK_6}, '{1'b0, 3'd4, BLK_8}, '{1'b0, 3'd4, BLK_8}
  };

endpackage

`default_nettype wire

>>> hdl/tmcs_if.sv
// Request and response channel interfaces of the mip chain size core.
`default_nettype none

interface tmcs_req_if #(
  parameter int unsigned EXTENT_BITS = tmcs_pkg::EXTENT_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic [tmcs_pkg::CODE_W-1:0]      format_code;
  logic [EXTENT_BITS-1:0]           tex_width;
  logic [EXTENT_BITS-1:0]           tex_height;
  logic [tmcs_pkg::REQ_W-1:0]       levels_requested;

  modport source (
    output valid, format_code, tex_width, tex_height, levels_requested,
    input  ready
  );
  modport sink (
    input  valid, format_code, tex_width, tex_height, levels_requested,
    output ready
  );
endinterface

interface tmcs_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [tmcs_pkg::TOTAL_W-1:0]     total_bytes;
  logic [tmcs_pkg::LEVELS_OUT_W-1:0] levels_used;
  logic                             format_unknown;

  modport source (
    output valid, total_bytes, levels_used, format_unknown,
    input  ready
  );
  modport sink (
    input  valid, total_bytes, levels_used, format_unknown,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/texture_mip_chain_size_core.sv
// A taken request passes through the register of every cell and then the output register.
// Throughput: one request per cycle; the chain of EXTENT_BITS + 3 cells moves every slot on
// each cycle, one mip level per cell, and freezes only while the output register is full.
// Reset: asynchronous, active low; clears the slot valid flags of every cell and the
// output valid flag. No clearing pass; a request may be taken in the first cycle after reset.
`default_nettype none

`include "texture_mip_chain_size_core_macros.svh"

module texture_mip_chain_size_core #(
  parameter int unsigned EXTENT_BITS = tmcs_pkg::EXTENT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tmcs_req_if.sink   req,
  tmcs_rsp_if.source rsp
);

  localparam int unsigned NCELLS = EXTENT_BITS + 3;
  localparam int unsigned LVL_W  = $clog2(EXTENT_BITS + 2);

  tmcs_pkg::ctl_t                  ctl   [NCELLS+1];
  logic [EXTENT_BITS-1:0]          mw    [NCELLS+1];
  logic [EXTENT_BITS-1:0]          mh    [NCELLS+1];
  logic [tmcs_pkg::REQ_W-1:0]      rem   [NCELLS+1];
  logic [LVL_W-1:0]                lvl   [NCELLS+1];
  logic [EXTENT_BITS-1:0]          bx    [NCELLS+1];
  logic [EXTENT_BITS-1:0]          by    [NCELLS+1];
  logic [tmcs_pkg::TOTAL_W-1:0]    prod  [NCELLS+1];
  logic [tmcs_pkg::TOTAL_W-1:0]    total [NCELLS+1];

  logic                            en_chain;
  logic                            accept;
  logic                            unknown;
  logic                            out_load;
  logic                            out_vld_d, out_vld_q;
  logic [tmcs_pkg::TOTAL_W-1:0]    out_total_q;
  logic [LVL_W-1:0]                out_lvl_q;
  logic                            out_unknown_q;

  // Chain holds only when the last slot is full and cannot drain
  assign en_chain  = !ctl[NCELLS].vld || !out_vld_q || rsp.ready;
  assign req.ready = en_chain;
  assign accept    = req.valid && en_chain;
  assign unknown   = req.format_code >= tmcs_pkg::CODE_W'(tmcs_pkg::FMT_ROWS);

  always_comb begin
    ctl[0].vld     = accept;
    ctl[0].bvld    = 1'b0;
    ctl[0].pvld    = 1'b0;
    ctl[0].unknown = unknown;
    ctl[0].fmt     = unknown ? tmcs_pkg::FMT_NONE : tmcs_pkg::FMT_TABLE[req.format_code];
    mw[0]          = req.tex_width;
    mh[0]          = req.tex_height;
    // a zero side means no levels at all
    rem[0]         = ((req.tex_width == '0) || (req.tex_height == '0)) ?
                     '0 : req.levels_requested;
    lvl[0]         = '0;
    bx[0]          = '0;
    by[0]          = '0;
    prod[0]        = '0;
    total[0]       = '0;
  end

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    tmcs_cell #(
      .EXTENT_BITS (EXTENT_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_chain),
      .ctl_i   (ctl[i]),
      .mw_i    (mw[i]),
      .mh_i    (mh[i]),
      .rem_i   (rem[i]),
      .lvl_i   (lvl[i]),
      .bx_i    (bx[i]),
      .by_i    (by[i]),
      .prod_i  (prod[i]),
      .total_i (total[i]),
      .ctl_o   (ctl[i+1]),
      .mw_o    (mw[i+1]),
      .mh_o    (mh[i+1]),
      .rem_o   (rem[i+1]),
      .lvl_o   (lvl[i+1]),
      .bx_o    (bx[i+1]),
      .by_o    (by[i+1]),
      .prod_o  (prod[i+1]),
      .total_o (total[i+1])
    );
  end

  assign out_load = ctl[NCELLS].vld && (!out_vld_q || rsp.ready);

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (rsp.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_total_q   <= total[NCELLS];
      out_lvl_q     <= lvl[NCELLS];
      out_unknown_q <= ctl[NCELLS].unknown;
    end
  end

  assign rsp.valid          = out_vld_q;
  assign rsp.total_bytes    = out_total_q;
  assign rsp.levels_used    = tmcs_pkg::LEVELS_OUT_W'(out_lvl_q);
  assign rsp.format_unknown = out_unknown_q;

  `TMCS_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, accept, ctl[1].vld, "accepted transaction did not enter the chain")
  `TMCS_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, !en_chain, ctl[NCELLS].vld && out_vld_q, "stalled chain lost its last slot")
  `TMCS_ASSERT_NOW(a_unknown_zero, clk_i, rst_ni, rsp.valid && rsp.format_unknown, rsp.total_bytes == '0, "unknown format gave non-zero size")
  `TMCS_ASSERT_NOW(a_load_free, clk_i, rst_ni, out_load && out_vld_q, rsp.ready, "output register overwritten before transfer")

endmodule

`default_nettype wire

>>> hdl/tmcs_cell.sv
// One cell of the chain: block count of one level, product of the previous
// level and accumulation of the one before that.
`default_nettype none

module tmcs_cell #(
  parameter int unsigned EXTENT_BITS = tmcs_pkg::EXTENT_BITS_DEF,
  localparam int unsigned LVL_W      = $clog2(EXTENT_BITS + 2)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  tmcs_pkg::ctl_t                ctl_i,
  input  logic [EXTENT_BITS-1:0]        mw_i,
  input  logic [EXTENT_BITS-1:0]        mh_i,
  input  logic [tmcs_pkg::REQ_W-1:0]    rem_i,
  input  logic [LVL_W-1:0]              lvl_i,
  input  logic [EXTENT_BITS-1:0]        bx_i,
  input  logic [EXTENT_BITS-1:0]        by_i,
  input  logic [tmcs_pkg::TOTAL_W-1:0]  prod_i,
  input  logic [tmcs_pkg::TOTAL_W-1:0]  total_i,
  output tmcs_pkg::ctl_t                ctl_o,
  output logic [EXTENT_BITS-1:0]        mw_o,
  output logic [EXTENT_BITS-1:0]        mh_o,
  output logic [tmcs_pkg::REQ_W-1:0]    rem_o,
  output logic [LVL_W-1:0]              lvl_o,
  output logic [EXTENT_BITS-1:0]        bx_o,
  output logic [EXTENT_BITS-1:0]        by_o,
  output logic [tmcs_pkg::TOTAL_W-1:0]  prod_o,
  output logic [tmcs_pkg::TOTAL_W-1:0]  total_o
);

  localparam int unsigned EW    = EXTENT_BITS + 3;

  // ceil(m / block) for block sizes 1, 4, 6 and 8
  function automatic logic [EXTENT_BITS-1:0] blk_count(
    input logic [EXTENT_BITS-1:0] m,
    input tmcs_pkg::blk_e         k
  );
    logic [EW-1:0]            me;
    logic [31:0]              u;
    logic [63:0]              p;
    logic [EXTENT_BITS-1:0]   r;
    me = {3'b000, m};
    u  = '0;
    p  = '0;
    unique case (k)
      tmcs_pkg::BLK_1: r = m;
      tmcs_pkg::BLK_4: r = EXTENT_BITS'((me + EW'(3)) >> 2);
      tmcs_pkg::BLK_6: begin
        // ceil(m/6) = ceil(ceil(m/2)/3)
        u = 32'((me + EW'(1)) >> 1) + 32'd2;
        p = {32'd0, u} * tmcs_pkg::DIV3_RECIP;
        r = EXTENT_BITS'(p >> tmcs_pkg::DIV3_SHIFT);
      end
      tmcs_pkg::BLK_8: r = EXTENT_BITS'((me + EW'(7)) >> 3);
      default:         r = m;
    endcase
    return r;
  endfunction

  logic                            active;
  logic [EXTENT_BITS-1:0]          mw1, mh1;
  logic [2*EXTENT_BITS-1:0]        pr;
  tmcs_pkg::ctl_t                  ctl_d, ctl_q;
  logic [EXTENT_BITS-1:0]          mw_d, mw_q, mh_d, mh_q, bx_d, bx_q, by_d, by_q;
  logic [tmcs_pkg::REQ_W-1:0]      rem_d, rem_q;
  logic [LVL_W-1:0]                lvl_d, lvl_q;
  logic [tmcs_pkg::TOTAL_W-1:0]    prod_d, prod_q, total_d, total_q;

  // A level counts while requests remain and the larger side has not run out
  assign active = ctl_i.vld && (rem_i != '0) && ((mw_i | mh_i) != '0);
  assign mw1    = (mw_i == '0) ? EXTENT_BITS'(1) : mw_i;
  assign mh1    = (mh_i == '0) ? EXTENT_BITS'(1) : mh_i;
  assign pr     = bx_i * by_i;

  always_comb begin
    ctl_d      = ctl_i;
    ctl_d.bvld = active && !ctl_i.fmt.zero;
    ctl_d.pvld = ctl_i.bvld;
    mw_d       = mw_i >> 1;
    mh_d       = mh_i >> 1;
    rem_d      = rem_i - tmcs_pkg::REQ_W'(active);
    lvl_d      = lvl_i + LVL_W'(active);
    bx_d       = blk_count(mw1, ctl_i.fmt.blk);
    by_d       = blk_count(mh1, ctl_i.fmt.blk);
    prod_d     = tmcs_pkg::TOTAL_W'(pr) << ctl_i.fmt.bsh;
    total_d    = total_i + (ctl_i.pvld ? prod_i : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mw_q    <= mw_d;
      mh_q    <= mh_d;
      rem_q   <= rem_d;
      lvl_q   <= lvl_d;
      bx_q    <= bx_d;
      by_q    <= by_d;
      prod_q  <= prod_d;
      total_q <= total_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign mw_o    = mw_q;
  assign mh_o    = mh_q;
  assign rem_o   = rem_q;
  assign lvl_o   = lvl_q;
  assign bx_o    = bx_q;
  assign by_o    = by_q;
  assign prod_o  = prod_q;
  assign total_o = total_q;

endmodule

`default_nettype wire

>>> dv/texture_mip_chain_size_core_tb.sv
// Self-checking testbench for the mip chain size core: random and directed size queries.
`timescale 1ns / 1ps

module texture_mip_chain_size_core_tb;
  import tmcs_pkg::*;

  localparam int unsigned EXT_W        = EXTENT_BITS_DEF;
  localparam int unsigned PIPE_LATENCY = EXT_W + 3;
  localparam int unsigned DRAIN_CYCLES = 2 * PIPE_LATENCY + 20;
  localparam int unsigned RANDOM_REQS  = 1300;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned MAX_WAIT     = 17;
  localparam int unsigned PRINT_CAP    = 40;

  // Format codes used by the directed part
  localparam logic [CODE_W-1:0] FMT_NO_BYTES  = 5'd0;
  localparam logic [CODE_W-1:0] FMT_R8        = 5'd1;
  localparam logic [CODE_W-1:0] FMT_RGBA16F   = 5'd7;
  localparam logic [CODE_W-1:0] FMT_BC1       = 5'd11;
  localparam logic [CODE_W-1:0] FMT_BC3       = 5'd13;
  localparam logic [CODE_W-1:0] FMT_ASTC6     = 5'd22;
  localparam logic [CODE_W-1:0] FMT_ASTC8     = 5'd24;
  localparam logic [CODE_W-1:0] FMT_LAST_ROW  = 5'd25;
  localparam logic [CODE_W-1:0] FMT_OUTSIDE   = 5'(FMT_ROWS);
  localparam logic [CODE_W-1:0] FMT_TOP_CODE  = 5'd31;

  // Bytes per block and square block edge, by format code
  localparam int unsigned FMT_BYTES [FMT_ROWS] = '{
    0, 1, 2, 4, 4, 2, 4, 8, 4, 4, 4,
    8, 8, 16, 16, 8, 16, 16, 16, 16, 16, 16,
    16, 16, 16, 16
  };
  localparam int unsigned FMT_EDGE [FMT_ROWS] = '{
    1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
    4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 4,
    6, 6, 8, 8
  };

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [EXT_W-1:0]  width;
    logic [EXT_W-1:0]  height;
    logic [REQ_W-1:0]  levels;
  } size_req_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]      total;
    logic [LEVELS_OUT_W-1:0] levels;
    logic                    unknown;
  } size_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tmcs_req_if #(.EXTENT_BITS(EXT_W)) req_if ();
  tmcs_rsp_if                        rsp_if ();

  texture_mip_chain_size_core #(
    .EXTENT_BITS(EXT_W)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_if),
    .rsp   (rsp_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  size_req_t   pending_requests[$];
  size_rsp_t   expected_sizes[$];
  size_req_t   on_bus;
  int unsigned req_gap;
  int unsigned rsp_stall;
  int unsigned n_sent;
  int unsigned n_received;
  int unsigned n_unknown;
  int unsigned n_clamped;
  int unsigned n_mismatch;
  int unsigned cycle_cnt;

  // Byte size of the clamped mip chain for one query
  function automatic size_rsp_t mip_chain_bytes(input size_req_t q);
    size_rsp_t       r;
    longint unsigned bpb, edge_len, big, mw, mh, sum;
    int unsigned     chain, used, lv;
    r.unknown = (q.code >= FMT_ROWS);
    bpb       = 0;
    edge_len  = 1;
    if (!r.unknown) begin
      bpb      = FMT_BYTES[q.code];
      edge_len = FMT_EDGE[q.code];
    end
    sum  = 0;
    used = 0;
    if (q.width != 0 && q.height != 0 && q.levels != 0) begin
      big   = (q.width > q.height) ? q.width : q.height;
      chain = 1;
      while (big > 1) begin
        big = big >> 1;
        chain++;
      end
      used = (q.levels < chain) ? q.levels : chain;
      for (lv = 0; lv < used; lv++) begin
        mw = longint'(q.width) >> lv;
        mh = longint'(q.height) >> lv;
        if (mw == 0) mw = 1;
        if (mh == 0) mh = 1;
        sum += ((mw + edge_len - 1) / edge_len) * ((mh + edge_len - 1) / edge_len) * bpb;
      end
    end
    r.total  = sum[TOTAL_W-1:0];
    r.levels = used[LEVELS_OUT_W-1:0];
    return r;
  endfunction

  // Per-transaction wait; each side gets its own idle-free stretch
  function automatic int unsigned draw_wait(input int unsigned count, input int unsigned phase);
    if ((count / 100) % 5 == phase) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [EXT_W-1:0] rand_extent();
    int unsigned sel;
    sel = $urandom_range(0, 31);
    if (sel == 0) return '0;
    if (sel < 12) return EXT_W'($urandom_range(1, 64));
    if (sel < 18) return EXT_W'((32'd1 << $urandom_range(0, EXT_W - 1)) + $urandom_range(0, 2) - 1);
    if (sel < 22) return EXT_W'({EXT_W{1'b1}} - $urandom_range(0, 3));
    return EXT_W'($urandom_range(1, (1 << EXT_W) - 1));
  endfunction

  task automatic queue_query(input logic [CODE_W-1:0] code, input logic [EXT_W-1:0] w,
                             input logic [EXT_W-1:0] h, input logic [REQ_W-1:0] lv);
    pending_requests.push_back('{code: code, width: w, height: h, levels: lv});
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (n_mismatch < PRINT_CAP)
      $display("[%0t] mismatch, %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    n_mismatch++;
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid            <= 1'b0;
      req_if.format_code      <= '0;
      req_if.tex_width        <= '0;
      req_if.tex_height       <= '0;
      req_if.levels_requested <= '0;
      req_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_sizes.push_back(mip_chain_bytes(on_bus));
        if (on_bus.code >= FMT_ROWS) n_unknown++;
        if (on_bus.levels > expected_sizes[$].levels && on_bus.width != 0 &&
            on_bus.height != 0) n_clamped++;
        n_sent++;
        req_gap = draw_wait(n_sent, 2);
      end
      if (req_if.valid && !req_if.ready) begin
        // hold the transaction until taken
      end else if (req_gap != 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        on_bus = pending_requests.pop_front();
        req_if.valid            <= 1'b1;
        req_if.format_code      <= on_bus.code;
        req_if.tex_width        <= on_bus.width;
        req_if.tex_height       <= on_bus.height;
        req_if.levels_requested <= on_bus.levels;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    size_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_sizes.size() == 0) begin
          report_mismatch("result with nothing outstanding", rsp_if.total_bytes, 0);
        end else begin
          want = expected_sizes.pop_front();
          if (rsp_if.total_bytes !== want.total)
            report_mismatch("total_bytes", rsp_if.total_bytes, want.total);
          if (rsp_if.levels_used !== want.levels)
            report_mismatch("levels_used", rsp_if.levels_used, want.levels);
          if (rsp_if.format_unknown !== want.unknown)
            report_mismatch("format_unknown", rsp_if.format_unknown, want.unknown);
        end
        n_received++;
        rsp_stall = draw_wait(n_received, 3);
      end else if (rsp_stall != 0) begin
        rsp_stall--;
      end
      rsp_if.ready <= (rsp_stall == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_sizes.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned n_total;
    int unsigned sel;
    logic [REQ_W-1:0] lv;
    rst_ni                  = 1'b0;
    req_if.valid            = 1'b0;
    req_if.format_code      = '0;
    req_if.tex_width        = '0;
    req_if.tex_height       = '0;
    req_if.levels_requested = '0;
    rsp_if.ready            = 1'b0;

    // zero extents and zero level count
    queue_query(FMT_RGBA16F, 16'd0, 16'd100, 8'd5);
    queue_query(FMT_RGBA16F, 16'd100, 16'd0, 8'd5);
    queue_query(FMT_RGBA16F, 16'd64, 16'd64, 8'd0);
    queue_query(FMT_NO_BYTES, 16'd0, 16'd0, 8'd0);
    // zero-byte format still reports clamped levels
    queue_query(FMT_NO_BYTES, 16'd64, 16'd32, 8'hFF);
    // codes outside the table
    queue_query(FMT_OUTSIDE, 16'd64, 16'd64, 8'd3);
    queue_query(FMT_TOP_CODE, 16'hFFFF, 16'hFFFF, 8'hFF);
    queue_query(FMT_TOP_CODE, 16'd0, 16'd5, 8'd5);
    // largest extents
    queue_query(FMT_RGBA16F, 16'hFFFF, 16'hFFFF, 8'hFF);
    queue_query(FMT_ASTC8, 16'hFFFF, 16'hFFFF, 8'hFF);
    queue_query(FMT_ASTC6, 16'hFFFF, 16'hFFFF, 8'd17);
    queue_query(FMT_LAST_ROW, 16'hFFFF, 16'hFFFE, 8'hFF);
    // single texel and thin textures
    queue_query(FMT_BC1, 16'd1, 16'd1, 8'd1);
    queue_query(FMT_R8, 16'd1, 16'd1, 8'hFF);
    queue_query(FMT_BC1, 16'd1, 16'hFFFF, 8'hFF);
    queue_query(FMT_ASTC6, 16'hFFFF, 16'd1, 8'd16);
    queue_query(FMT_BC3, 16'h8000, 16'd4, 8'hFF);
    // partial blocks
    queue_query(FMT_ASTC6, 16'd7, 16'd13, 8'hFF);
    queue_query(FMT_ASTC8, 16'd9, 16'd17, 8'd2);
    // level count just below, at and above the full chain
    queue_query(FMT_RGBA16F, 16'd256, 16'd256, 8'd8);
    queue_query(FMT_RGBA16F, 16'd256, 16'd256, 8'd9);
    queue_query(FMT_RGBA16F, 16'd256, 16'd256, 8'd10);

    for (int unsigned i = 0; i < RANDOM_REQS; i++) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) lv = '0;
      else if (sel < 10) lv = REQ_W'($urandom_range(1, 18));
      else lv = REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
      queue_query(CODE_W'($urandom_range(0, (1 << CODE_W) - 1)), rand_extent(), rand_extent(), lv);
    end
    n_total = pending_requests.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (n_sent < n_total || expected_sizes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d size queries checked over %0d cycles: %0d with unknown format, %0d clamped",
             n_received, cycle_cnt, n_unknown, n_clamped);
    $display("%0d mismatches", n_mismatch);
    if (n_mismatch == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
